/* rtl/b64u_pkg.sv */
`timescale 1ns / 1ps

package b64u_pkg;

    // Position within the three-byte group, one-hot.
    typedef enum logic [2:0] {
        PH_0 = 3'b001,
        PH_1 = 3'b010,
        PH_2 = 3'b100
    } t_phase;

    typedef logic [5:0] t_sextet;
    typedef logic [6:0] t_char;

    localparam int unsigned LEFT_W  = 4;

    // Maps a sextet to its URL-safe base64 character (A-Z a-z 0-9 - _).
    function automatic t_char sextet_to_char(input t_sextet s);
        t_char c;
        if (s < 6'd26) begin
            c = 7'h41 + {1'b0, s};
        end else if (s < 6'd52) begin
            c = 7'h61 + {1'b0, s} - 7'd26;
        end else if (s < 6'd62) begin
            c = 7'h30 + {1'b0, s} - 7'd52;
        end else if (s == 6'd62) begin
            c = 7'h2d;
        end else begin
            c = 7'h5f;
        end
        return c;
    endfunction

endpackage

/* rtl/base64url_stream_encoder_core.sv */
`timescale 1ns / 1ps

// Channel | Direction | tdata (low bit up)        | tlast
// --------+-----------+---------------------------+-------------------------
// s       | in        | [7:0] data_byte           | last_byte of the message
// m       | out       | [6:0] out_char, [7] zero  | last_char of the message
//
// An accepted byte is encoded in the same cycle into one or two characters,
// which are held in a two-entry character buffer ahead of the output register.
// A byte that yields one character is taken every cycle while the output
// is not stalled; a byte that yields two holds the buffer until the
// single-character output channel has moved both on to the output register.
// Reset (i_rst_n low, synchronous) empties the buffer and output register
// and returns the group phase to the start of a group.
// A stall on the output fills the buffer and then drops o_s_tready; no
// character is lost or repeated.
module base64url_stream_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // last_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [6:0] out_char, [7] zero fill
    output logic       o_m_tlast    // last_char
);

    // Group position and the low bits of the previous byte not yet emitted.
    b64u_pkg::t_phase            r_phase, n_phase;
    logic [b64u_pkg::LEFT_W-1:0] r_left,  n_left;

    // Character buffer: entry 0 is the next character to leave.
    logic [1:0]       r_hn;
    b64u_pkg::t_char  r_c0, r_c1;
    logic             r_l0, r_l1;

    // Output register.
    logic             r_ov;
    b64u_pkg::t_char  r_oc;
    logic             r_ol;

    logic             s_accept;
    logic             out_load;
    logic             move;
    b64u_pkg::t_sextet s0, s1;
    logic [1:0]       n_cnt;

    // The output register takes a new character when empty or being drained.
    assign out_load = !r_ov || i_m_tready;
    assign move     = (r_hn != 2'd0) && out_load;

    // Ready when the buffer will be empty after this cycle.
    assign o_s_tready = (r_hn == 2'd0) || ((r_hn == 2'd1) && move);
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Split the byte into sextets according to the group phase.
    always_comb begin
        n_left  = r_left;
        n_phase = r_phase;
        unique case (r_phase)
            b64u_pkg::PH_1: begin
                s0      = {r_left[1:0], i_s_tdata[7:4]};
                s1      = {i_s_tdata[3:0], 2'b00};
                n_cnt   = i_s_tlast ? 2'd2 : 2'd1;
                n_left  = i_s_tdata[3:0];
                n_phase = b64u_pkg::PH_2;
            end
            b64u_pkg::PH_2: begin
                s0      = {r_left, i_s_tdata[7:6]};
                s1      = i_s_tdata[5:0];
                n_cnt   = 2'd2;
                n_left  = '0;
                n_phase = b64u_pkg::PH_0;
            end
            default: begin
                s0      = i_s_tdata[7:2];
                s1      = {i_s_tdata[1:0], 4'b0000};
                n_cnt   = i_s_tlast ? 2'd2 : 2'd1;
                n_left  = {2'b00, i_s_tdata[1:0]};
                n_phase = b64u_pkg::PH_1;
            end
        endcase
        // The end of a message starts the next one at a fresh group.
        if (i_s_tlast) begin
            n_left  = '0;
            n_phase = b64u_pkg::PH_0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64u_pkg::PH_0;
            r_left  <= '0;
        end else if (s_accept) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    // Character buffer. A new byte loads both entries; otherwise a move
    // shifts entry 1 down or empties the buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hn <= 2'd0;
        end else if (s_accept) begin
            r_hn <= n_cnt;
        end else if (move) begin
            r_hn <= r_hn - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            // The first character of a byte is never the final one.
            r_c0 <= b64u_pkg::sextet_to_char(s0);
            r_l0 <= 1'b0;
            r_c1 <= b64u_pkg::sextet_to_char(s1);
            r_l1 <= i_s_tlast;
        end else if (move) begin
            r_c0 <= r_c1;
            r_l0 <= r_l1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= (r_hn != 2'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_oc <= r_c0;
            r_ol <= r_l0;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {1'b0, r_oc};
    assign o_m_tlast  = r_ol;

    // The buffer never holds more than two characters.
    a_hn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hn != 2'd3)
        else $error("character buffer count out of range");

    // A byte is only taken when the buffer has room for it.
    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> r_hn != 2'd2)
        else $error("ready raised with a full buffer");

    // A last byte returns the encoder to the start of a group.
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tlast) |=> (r_phase == b64u_pkg::PH_0 && r_left == '0))
        else $error("group state not cleared after last byte");

    // A last byte always queues two characters, the second marked last.
    a_last_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tlast) |=> (r_hn == 2'd2 && r_l1 && !r_l0))
        else $error("last byte did not queue a final character");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned STALL_LIMIT  = 2000;

    // One expected character as it should appear on the master side.
    typedef struct {
        b64u_pkg::t_char ch;
        logic            last;
    } t_char_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;     // [7:0] data_byte
    logic       s_tlast = 1'b0;   // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b1;
    logic [7:0] m_tdata;          // [6:0] out_char, [7] zero fill
    logic       m_tlast;          // last_char

    // Idling on both sides; turned off for the closing full-rate part.
    bit          idling_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;

    // Encoder state as predicted from the accepted bytes.
    b64u_pkg::t_phase enc_phase = b64u_pkg::PH_0;
    logic [3:0]       enc_left = '0;
    t_char_item       pending_chars[$];

    string URL_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    base64url_stream_encoder_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic push_sextet(input logic [5:0] sextet, input logic last);
        t_char_item item;
        item.ch = b64u_pkg::t_char'(URL_ALPHABET[sextet]);
        item.last = last;
        pending_chars.push_back(item);
    endtask

    // Expected characters for one accepted byte, and the new group state.
    task automatic encode_byte(input logic [7:0] b, input logic last);
        case (enc_phase)
            b64u_pkg::PH_1: begin
                push_sextet({enc_left[1:0], b[7:4]}, 1'b0);
                if (last) begin
                    push_sextet({b[3:0], 2'b00}, 1'b1);
                end
                enc_left = b[3:0];
                enc_phase = b64u_pkg::PH_2;
            end
            b64u_pkg::PH_2: begin
                push_sextet({enc_left, b[7:6]}, 1'b0);
                push_sextet(b[5:0], last);
                enc_left = '0;
                enc_phase = b64u_pkg::PH_0;
            end
            default: begin
                push_sextet(b[7:2], 1'b0);
                if (last) begin
                    push_sextet({b[1:0], 4'b0000}, 1'b1);
                end
                enc_left = {2'b00, b[1:0]};
                enc_phase = b64u_pkg::PH_1;
            end
        endcase
        // A closed message always leaves the encoder at the start of a group.
        if (last) begin
            enc_phase = b64u_pkg::PH_0;
            enc_left = '0;
        end
    endtask

    // Offers one byte, with a random gap in front of it, and waits until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            // Junk on the data lines while the valid is low.
            s_tvalid = 1'b0;
            s_tdata = 8'($urandom_range(0, 255));
            s_tlast = 1'($urandom_range(0, 1));
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tlast = last;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        encode_byte(b, last);
    endtask

    // Receiver: bursts of back-pressure while idling is on.
    always @(negedge i_clk) begin
        if (!idling_on) begin
            stall_left = 0;
            m_tready = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            m_tready = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    // Each accepted character is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_char_item want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h", m_tdata));
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata[6:0] !== want.ch) begin
                    report_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
                                              m_tdata[6:0], want.ch));
                end
                if (m_tdata[7] !== 1'b0) begin
                    report_mismatch("tdata fill bit is not zero");
                end
                if (m_tlast !== want.last) begin
                    report_mismatch($sformatf("last_char %b, want %b", m_tlast, want.last));
                end
            end
        end
    end

    // Watchdog: too many cycles in a row with no handshake on either side.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Short messages that end at each group phase, all-zero and all-one bytes,
    // and a run that produces the two URL-safe characters.
    task automatic test_directed();
        logic [8:0] seq[$];
        seq = '{9'h100, 9'h1ff,
                9'h000, 9'h1ff,
                9'h0ff, 9'h000, 9'h1ff,
                9'h0fb, 9'h0ff, 9'h0bf, 9'h000, 9'h010, 9'h183,
                9'h0aa, 9'h055, 9'h012, 9'h134,
                9'h0ff, 9'h0fc, 9'h1fe};
        foreach (seq[i]) begin
            send_byte(seq[i][7:0], seq[i][8]);
        end
    endtask

    // Messages of random content, mostly short, some long.
    task automatic test_random_messages(input int unsigned n_bytes);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(10, 48);
            end else begin
                len = $urandom_range(1, 8);
            end
            for (int unsigned k = 0; k < len; k++) begin
                send_byte(8'($urandom_range(0, 255)), k == len - 1);
            end
            sent += len;
        end
    endtask

    // Same stream with no idling on either side.
    task automatic test_full_rate(input int unsigned n_bytes);
        idling_on = 1'b0;
        test_random_messages(n_bytes);
    endtask

    task automatic finish_run();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_messages(1350);
        test_full_rate(330);
        finish_run();
    end

endmodule
